// File: rtl/core/damm_check_digit_8digit_defines.svh
// Assertion macros used by the checker file.
`ifndef DAMM_CHECK_DIGIT_8DIGIT_DEFINES_SVH
`define DAMM_CHECK_DIGIT_8DIGIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("damm check digit: assertion failed");

// Check that a cause is followed by a consequence after the delay given by lat.
`define DCD_ASSERT_LAT(lbl, clk, rst_n, ante, lat, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
		else $error("damm check digit: latency assertion failed");

`endif

// File: rtl/core/dcd_pkg.sv
`default_nettype none
package dcd_pkg;

	localparam int NUM_DIGITS = 8;
	localparam int VAL_W      = 27;
	localparam int DIG_W      = 4;
	localparam int MUL_W      = 31;
	localparam int DIGIT_MAX  = 9;
	// input register plus one cell per digit
	localparam int LATENCY    = NUM_DIGITS + 1;

	typedef logic [DIGIT_MAX-1:0][MUL_W-1:0] mult_t;

	typedef struct packed {
		logic             vld;
		logic             oor;
		logic [VAL_W-1:0] rem;
		logic [DIG_W-1:0] interim;
	} cell_t;

	localparam logic [DIG_W-1:0] DAMM_TAB [10][10] = '{
		'{4'd0, 4'd3, 4'd1, 4'd7, 4'd5, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2},
		'{4'd7, 4'd0, 4'd9, 4'd2, 4'd1, 4'd5, 4'd4, 4'd8, 4'd6, 4'd3},
		'{4'd4, 4'd2, 4'd0, 4'd6, 4'd8, 4'd7, 4'd1, 4'd3, 4'd5, 4'd9},
		'{4'd1, 4'd7, 4'd5, 4'd0, 4'd9, 4'd8, 4'd3, 4'd4, 4'd2, 4'd6},
		'{4'd6, 4'd1, 4'd2, 4'd3, 4'd0, 4'd4, 4'd5, 4'd9, 4'd7, 4'd8},
		'{4'd3, 4'd6, 4'd7, 4'd4, 4'd2, 4'd0, 4'd9, 4'd5, 4'd8, 4'd1},
		'{4'd5, 4'd8, 4'd6, 4'd9, 4'd7, 4'd2, 4'd0, 4'd1, 4'd3, 4'd4},
		'{4'd8, 4'd9, 4'd4, 4'd5, 4'd3, 4'd6, 4'd2, 4'd0, 4'd1, 4'd7},
		'{4'd9, 4'd4, 4'd3, 4'd8, 4'd6, 4'd1, 4'd7, 4'd2, 4'd0, 4'd5},
		'{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd3, 4'd6, 4'd7, 4'd9, 4'd0}
	};

	function automatic logic [MUL_W-1:0] pow10(input int k);
		logic [MUL_W-1:0] p;
		p = MUL_W'(1);
		for (int i = 0; i < k; i++) begin
			p = MUL_W'(p * 10);
		end
		return p;
	endfunction

	// 1x .. 9x the weight of the digit at position k
	function automatic mult_t digit_mults(input int k);
		mult_t            m;
		logic [MUL_W-1:0] p;
		p = pow10(k);
		for (int j = 0; j < DIGIT_MAX; j++) begin
			m[j] = MUL_W'(p * (j + 1));
		end
		return m;
	endfunction

	localparam logic [MUL_W-1:0] LIMIT = pow10(NUM_DIGITS);

	function automatic logic [DIG_W-1:0] damm_next(input logic [DIG_W-1:0] interim,
		input logic [DIG_W-1:0] digit);
		return DAMM_TAB[interim][digit];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/dcd_cell.sv
`default_nettype none
module dcd_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dcd_pkg::mult_t mults,
	input  wire dcd_pkg::cell_t din,
	output dcd_pkg::cell_t     dout
);
	import dcd_pkg::*;

	logic [DIG_W-1:0] digit;
	logic [MUL_W-1:0] sub;
	logic             vld_q;
	logic             oor_q;
	logic [VAL_W-1:0] rem_q;
	logic [DIG_W-1:0] interim_q;

	// peel off the leading digit: largest multiple of the weight not above rem
	always_comb begin
		digit = '0;
		sub   = '0;
		for (int j = 0; j < DIGIT_MAX; j++) begin
			if (MUL_W'(din.rem) >= mults[j]) begin
				digit = DIG_W'(j + 1);
				sub   = mults[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		oor_q     <= din.oor;
		rem_q     <= din.rem - sub[VAL_W-1:0];
		interim_q <= damm_next(din.interim, digit);
	end

	assign dout = '{vld: vld_q, oor: oor_q, rem: rem_q, interim: interim_q};

endmodule
`default_nettype wire

// File: rtl/core/damm_check_digit_8digit.sv
`default_nettype none
// Channel | Ports                              | Handshake
// --------+------------------------------------+---------------------------------
// item in | value[26:0]                        | start high while busy low
// result  | check_digit[3:0], out_of_range     | done high for one cycle, no stall
//
// One item enters per cycle; busy never rises.
// The path runs through one input register, then one cell per
// decimal digit, most significant first, each doing a compare bank and a table step.
// Reset clears only the valid bits along the chain; payload registers keep no reset.
// The result drives straight from the last cell's registers; the receiver cannot stall.
module damm_check_digit_8digit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [dcd_pkg::VAL_W-1:0] value,
	output logic                           done,
	output logic [dcd_pkg::DIG_W-1:0]      check_digit,
	output logic                           out_of_range
);
	import dcd_pkg::*;

	logic             vld_s1;
	logic             oor_s1;
	logic [VAL_W-1:0] rem_s1;
	cell_t            chain [NUM_DIGITS+1];

	// the chain never backs up
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	// flag oversized numbers and drop their value: a zero runs through the
	// table as zero, so the digit comes out 0
	always_ff @(posedge clk) begin
		oor_s1 <= (MUL_W'(value) >= LIMIT);
		rem_s1 <= (MUL_W'(value) >= LIMIT) ? '0 : value;
	end

	assign chain[0] = '{vld: vld_s1, oor: oor_s1, rem: rem_s1, interim: '0};

	// advance one digit per cell, highest weight first
	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
		localparam mult_t MULTS = digit_mults(NUM_DIGITS - 1 - g);

		dcd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.mults  (MULTS),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	assign done         = chain[NUM_DIGITS].vld;
	assign check_digit  = chain[NUM_DIGITS].interim;
	assign out_of_range = chain[NUM_DIGITS].oor;

endmodule
`default_nettype wire

// File: rtl/core/dcd_chk.sv
`default_nettype none
`include "damm_check_digit_8digit_defines.svh"
module dcd_chk (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic [dcd_pkg::VAL_W-1:0] value,
	input wire logic                      done,
	input wire logic [dcd_pkg::DIG_W-1:0] check_digit,
	input wire logic                      out_of_range
);
	import dcd_pkg::*;

	logic take;
	logic big;

	assign take = start && !busy;
	assign big  = (MUL_W'(value) >= LIMIT);

	`DCD_ASSERT(a_digit_range, clk, arst_n, !done || (check_digit <= 4'd9))
	`DCD_ASSERT(a_oor_zero, clk, arst_n, !(done && out_of_range) || (check_digit == '0))
	`DCD_ASSERT_LAT(a_latency, clk, arst_n, take, LATENCY, done)
	`DCD_ASSERT_LAT(a_oor_flag, clk, arst_n, take && big, LATENCY, done && out_of_range)

endmodule

bind damm_check_digit_8digit dcd_chk u_dcd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.value        (value),
	.done         (done),
	.check_digit  (check_digit),
	.out_of_range (out_of_range)
);
`default_nettype wire
